### hdl/ltq_pkg.sv
`default_nettype none
package ltq_pkg;

  localparam int unsigned QDEPTH = 2;

  // one accepted segment after the front has taken its differences
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic [30:0] w;
    logic zero;
  } ltq_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ltq_status_t;

  localparam logic [1:0] REG_CAM_X = 2'd0;
  localparam logic [1:0] REG_CAM_Y = 2'd1;
  localparam logic [1:0] REG_CAM_Z = 2'd2;

endpackage
`default_nettype wire

### hdl/ltq_front.sv
`default_nettype none
module ltq_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [31:0] sx, sy, sz, ex, ey, ez,
  input  wire logic [30:0] w,
  output logic q_valid,
  input  wire logic q_ready,
  output ltq_pkg::ltq_item_t q_item
);
  ltq_pkg::ltq_item_t mem [ltq_pkg::QDEPTH];
  logic wp, rp;
  logic [1:0] cnt;
  ltq_pkg::ltq_item_t it;

  always_comb begin
    it.dx = 33'(ex) - 33'(sx);
    it.dy = 33'(ey) - 33'(sy);
    it.dz = 33'(ez) - 33'(sz);
    it.sx = sx; it.sy = sy; it.sz = sz;
    it.ex = ex; it.ey = ey; it.ez = ez;
    it.w = w;
    it.zero = (sx == ex) && (sy == ey) && (sz == ez);
  end

  assign in_ready = cnt != 2'd2;
  assign q_valid = cnt != 2'd0;
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= it;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

### hdl/ltq_back.sv
`default_nettype none
module ltq_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic signed [31:0] cam_x, cam_y, cam_z,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire ltq_pkg::ltq_item_t q_item,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] corner_index,
  output logic signed [31:0] corner_x, corner_y, corner_z,
  output logic [31:0] mean_distance,
  output logic zero_length,
  output logic last_corner,
  output ltq_pkg::ltq_status_t status
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DIR = 4'd1, S_NORM = 4'd2, S_SQ = 4'd3,
    S_SQRT = 4'd4, S_DIV = 4'd5, S_DIST = 4'd6, S_DSQ = 4'd7, S_DRT = 4'd8, S_EMIT = 4'd9;
  logic [3:0] st;
  ltq_pkg::ltq_item_t c;
  logic [32:0] b0, b1, b2;
  logic sg0, sg1, sg2;
  logic [55:0] sq0, sq1, sq2;
  logic [63:0] sqsum;
  logic [67:0] rem, root, pw;
  logic [67:0] rt_sum, rem_nx, root_nx;
  logic rt_ge;
  logic [1:0] cmp;
  logic [27:0] bdiv;
  logic [58:0] prod;
  logic [62:0] num;
  logic [62:0] dvd, dsr;
  logic [30:0] quo;
  logic [5:0] dcnt;
  logic signed [32:0] off0, off1, off2;
  logic dsel;
  logic [34:0] dsum;
  logic [31:0] dmag;
  logic [1:0] k;
  logic emit;

  logic big, small_mx, near_z;
  logic [32:0] mx;
  assign mx = (b0 > b1) ? ((b0 > b2) ? b0 : b2) : ((b1 > b2) ? b1 : b2);
  assign big = mx >= 33'(1 << 28);
  assign small_mx = mx < 33'(1 << 27);

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [32:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) sat = 33'sd2147483647;
    else if (v < -34'sd2147483648) sat = -33'sd2147483648;
    else sat = 33'(v);
  endfunction

  // one square root step, two radicand bits a cycle
  always_comb begin
    rt_sum = root + pw;
    rt_ge = rem >= rt_sum;
    rem_nx = rt_ge ? rem - rt_sum : rem;
    root_nx = rt_ge ? (root >> 1) + pw : root >> 1;
  end

  always_comb begin
    unique case (cmp)
      2'd0: begin bdiv = b0[27:0]; dmag = b0[31:0]; end
      2'd1: begin bdiv = b1[27:0]; dmag = b1[31:0]; end
      default: begin bdiv = b2[27:0]; dmag = b2[31:0]; end
    endcase
    prod = 59'(bdiv) * 59'(c.w);
    num = 63'(prod) + 63'(root[28:0]);
    sqsum = 64'(sq0) + 64'(sq1) + 64'(sq2);
    near_z = (64'(sq0) * 64'd100 < sqsum) && (64'(sq1) * 64'd100 < sqsum);
  end

  logic signed [33:0] bx, by, bz;
  logic signed [33:0] rx, ry, rz;
  logic sgn_neg;
  always_comb begin
    sgn_neg = (k == 2'd0) || (k == 2'd3);
    bx = k[1] ? 34'(c.ex) : 34'(c.sx);
    by = k[1] ? 34'(c.ey) : 34'(c.sy);
    bz = k[1] ? 34'(c.ez) : 34'(c.sz);
    rx = sgn_neg ? bx - 34'(off0) : bx + 34'(off0);
    ry = sgn_neg ? by - 34'(off1) : by + 34'(off1);
    rz = sgn_neg ? bz - 34'(off2) : bz + 34'(off2);
  end

  assign q_ready = st == S_IDLE;
  assign emit = (st == S_EMIT) && (!out_valid || out_ready);
  assign status.busy = st != S_IDLE;
  assign status.done = out_valid && out_ready && last_corner;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (q_valid) begin
          c <= q_item;
          b0 <= mag33(q_item.dx); b1 <= mag33(q_item.dy); b2 <= mag33(q_item.dz);
          st <= S_DIR;
        end
        S_DIR: if (big) begin
          b0 <= b0 >> 1; b1 <= b1 >> 1; b2 <= b2 >> 1;
        end else begin
          sq0 <= 56'(b0[27:0]) * 56'(b0[27:0]);
          sq1 <= 56'(b1[27:0]) * 56'(b1[27:0]);
          sq2 <= 56'(b2[27:0]) * 56'(b2[27:0]);
          st <= S_NORM;
        end
        S_NORM: begin
          // direction test, then choose perpendicular
          if (near_z) begin
            b0 <= mag33(c.dz); b1 <= 33'd0; b2 <= mag33(c.dx);
            sg0 <= !c.dz[32] && c.dz != 0; sg1 <= 1'b0; sg2 <= c.dx[32];
          end else begin
            b0 <= mag33(c.dy); b1 <= mag33(c.dx); b2 <= 33'd0;
            sg0 <= c.dy[32]; sg1 <= !c.dx[32] && c.dx != 0; sg2 <= 1'b0;
          end
          off0 <= '0; off1 <= '0; off2 <= '0;
          dsel <= 1'b0; dsum <= '0;
          st <= c.zero ? S_DIST : S_SQ;
        end
        S_SQ: if (big) begin
          b0 <= b0 >> 1; b1 <= b1 >> 1; b2 <= b2 >> 1;
        end else if (small_mx) begin
          b0 <= b0 << 1; b1 <= b1 << 1; b2 <= b2 << 1;
        end else begin
          rem <= 68'(56'(b0[27:0]) * 56'(b0[27:0])) + 68'(56'(b1[27:0]) * 56'(b1[27:0]))
               + 68'(56'(b2[27:0]) * 56'(b2[27:0]));
          root <= '0; pw <= 68'd1 << 66; st <= S_SQRT;
        end
        S_SQRT: begin
          rem <= rem_nx; root <= root_nx; pw <= pw >> 2;
          if (pw[0]) begin
            st <= S_DIV; cmp <= 2'd0; dcnt <= 6'd0;
          end
        end
        S_DIV: begin
          // one component a pass, restoring division one quotient bit a cycle
          if (dcnt == 6'd0) begin
            dvd <= num; quo <= '0; dsr <= 63'(root[28:0]) << 31; dcnt <= 6'd1;
          end else if (dcnt <= 6'd31) begin
            if (dvd >= dsr) begin
              dvd <= dvd - dsr;
              quo <= {quo[29:0], 1'b1};
            end else quo <= {quo[29:0], 1'b0};
            dsr <= dsr >> 1;
            dcnt <= dcnt + 6'd1;
          end else begin
            unique case (cmp)
              2'd0: off0 <= sg0 ? -33'(quo) : 33'(quo);
              2'd1: off1 <= sg1 ? -33'(quo) : 33'(quo);
              default: off2 <= sg2 ? -33'(quo) : 33'(quo);
            endcase
            dcnt <= 6'd0;
            if (cmp == 2'd2) st <= S_DIST; else cmp <= cmp + 2'd1;
          end
        end
        S_DIST: begin
          b0 <= mag33(33'(dsel ? c.ex : c.sx) - 33'(cam_x));
          b1 <= mag33(33'(dsel ? c.ey : c.sy) - 33'(cam_y));
          b2 <= mag33(33'(dsel ? c.ez : c.sz) - 33'(cam_z));
          rem <= '0; cmp <= 2'd0; st <= S_DSQ;
        end
        S_DSQ: begin
          rem <= rem + 68'(64'(dmag) * 64'(dmag));
          if (cmp == 2'd2) begin
            root <= '0; pw <= 68'd1 << 66; st <= S_DRT;
          end else cmp <= cmp + 2'd1;
        end
        S_DRT: begin
          rem <= rem_nx; root <= root_nx; pw <= pw >> 2;
          if (pw[0]) begin
            dsum <= dsum + 35'(root_nx);
            if (dsel) begin st <= S_EMIT; k <= 2'd0; end
            else begin dsel <= 1'b1; st <= S_DIST; end
          end
        end
        S_EMIT: if (emit) begin
          corner_index <= k;
          corner_x <= 32'(sat(rx)); corner_y <= 32'(sat(ry)); corner_z <= 32'(sat(rz));
          mean_distance <= dsum[34:1] > 34'hFFFFFFFF ? 32'hFFFFFFFF : dsum[32:1];
          zero_length <= c.zero;
          last_corner <= k == 2'd3;
          k <= k + 2'd1;
          if (k == 2'd3) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/line_to_quad_expansion.sv
`default_nettype none
// Thick line to quad expansion: each segment yields four corner transfers,
// start-offset, start+offset, end+offset, end-offset, all signed Q16.16, each
// carrying the mean endpoint distance to the camera set through the write port.
// A two-entry queue decouples input from the sequential back end, which works on
// one segment at a time: it takes the segment, scales the direction, makes the
// direction test, normalises the perpendicular, finds its length (square root,
// two bits a cycle), divides out each offset component in turn, finds each
// endpoint distance and emits the four corners; an output stall can hold it. A
// zero-length segment skips the normalisation, the length and the divider. Write
// the camera only while no segment is in flight.
module line_to_quad_expansion (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z,
  input  wire logic [30:0] stroke_width,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] corner_index,
  output logic signed [31:0] corner_x, corner_y, corner_z,
  output logic [31:0] mean_distance,
  output logic zero_length,
  output logic last_corner
);
  logic signed [31:0] camera_x, camera_y, camera_z;
  logic q_valid, q_ready;
  ltq_pkg::ltq_item_t q_item;
  ltq_pkg::ltq_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0; camera_y <= '0; camera_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ltq_pkg::REG_CAM_X: camera_x <= cfg_data;
        ltq_pkg::REG_CAM_Y: camera_y <= cfg_data;
        ltq_pkg::REG_CAM_Z: camera_z <= cfg_data;
        default: ;
      endcase
    end
  end

  ltq_front u_front (.clk, .rst, .in_valid, .in_ready,
    .sx(start_x), .sy(start_y), .sz(start_z), .ex(end_x), .ey(end_y), .ez(end_z),
    .w(stroke_width), .q_valid, .q_ready, .q_item);

  ltq_back u_back (.clk, .rst, .cam_x(camera_x), .cam_y(camera_y), .cam_z(camera_z),
    .q_valid, .q_ready, .q_item, .out_valid, .out_ready, .corner_index,
    .corner_x, .corner_y, .corner_z, .mean_distance, .zero_length, .last_corner, .status);

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_corner == (corner_index == 2'd3))) else $error("last flag");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status.busy || last_corner) else $error("output while idle");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    status.done |=> !out_valid || corner_index == 2'd0) else $error("corner order");
endmodule
`default_nettype wire
